// ----- hw/rtl/rmvi_pkg.sv -----
// Shared types, widths and codes for the region-masked volume integral block.
`default_nettype none

package rmvi_pkg;

  // Field widths
  localparam int COORD_BITS  = 16;
  localparam int VOLUME_BITS = 24;
  localparam int SUM_BITS    = 60;
  localparam int FRAC_BITS   = 16;
  localparam int SLOPE_BITS  = 16;
  localparam int SLOPE_FRAC  = 8;

  // Derived datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;              // |center - origin|
  localparam int SQ_W    = 2 * DIFF_W;                  // one squared offset
  localparam int SQ3_W   = SQ_W + 2;                    // sum of three squares
  localparam int LHS_W   = DIFF_W + SLOPE_FRAC;         // 256 * |dx|
  localparam int RHS_W   = DIFF_W + SLOPE_BITS - 1;     // positive slope * |dz apex|
  localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int PROD_W  = FRAC_BITS + VOLUME_BITS;     // fraction * volume
  localparam int ADD_W   = ((SUM_BITS > PROD_W) ? SUM_BITS : PROD_W) + 1;

  // Configuration port
  localparam int CFG_DATA_W = 3 * COORD_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int MODE_W     = 3;

  // Queue between classifier and accumulator
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SPHERE   = 3'd0,
    MODE_CYLINDER = 3'd1,
    MODE_BOX      = 3'd2,
    MODE_CONE     = 3'd3,
    MODE_NONE     = 3'd4
  } rmvi_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_ORIGIN    = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_HALF      = 3'd4,
    REG_APEX_Z    = 3'd5,
    REG_SLOPE     = 3'd6
  } rmvi_reg_e;

  // Decoded configuration
  typedef struct packed {
    rmvi_mode_e                    mode;
    logic [FRAC_BITS-1:0]          threshold;
    logic signed [COORD_BITS-1:0]  origin_x;
    logic signed [COORD_BITS-1:0]  origin_y;
    logic signed [COORD_BITS-1:0]  origin_z;
    logic [COORD_BITS-1:0]         radius;
    logic [COORD_BITS-1:0]         half_x;
    logic [COORD_BITS-1:0]         half_y;
    logic [COORD_BITS-1:0]         half_z;
    logic signed [COORD_BITS-1:0]  apex_z;
    logic signed [SLOPE_BITS-1:0]  slope;
  } rmvi_cfg_t;

  // One classified cell waiting for the accumulator
  typedef struct packed {
    logic              last;
    logic [PROD_W-1:0] addend;
  } rmvi_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rmvi_cfg_regs.sv -----
// Configuration register file: decodes indexed writes into the region settings.
`default_nettype none

module rmvi_cfg_regs
  import rmvi_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output rmvi_cfg_t                  cfg_o
);

  rmvi_cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rmvi_reg_e'(cfg_index_i))
        REG_MODE:      cfg_d.mode      = rmvi_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_THRESHOLD: cfg_d.threshold = cfg_data_i[FRAC_BITS-1:0];
        REG_ORIGIN: begin
          cfg_d.origin_x = cfg_data_i[COORD_BITS-1:0];
          cfg_d.origin_y = cfg_data_i[2*COORD_BITS-1:COORD_BITS];
          cfg_d.origin_z = cfg_data_i[3*COORD_BITS-1:2*COORD_BITS];
        end
        REG_RADIUS:    cfg_d.radius    = cfg_data_i[COORD_BITS-1:0];
        REG_HALF: begin
          cfg_d.half_x = cfg_data_i[COORD_BITS-1:0];
          cfg_d.half_y = cfg_data_i[2*COORD_BITS-1:COORD_BITS];
          cfg_d.half_z = cfg_data_i[3*COORD_BITS-1:2*COORD_BITS];
        end
        REG_APEX_Z:    cfg_d.apex_z    = cfg_data_i[COORD_BITS-1:0];
        REG_SLOPE:     cfg_d.slope     = cfg_data_i[SLOPE_BITS-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_CONE, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rmvi_front.sv -----
// Front end: accepts cells, runs the region test and fraction * volume in two stages.
`default_nettype none

module rmvi_front
  import rmvi_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rmvi_cfg_t                     cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_BITS-1:0]  cell_x_i,
  input  wire logic signed [COORD_BITS-1:0]  cell_y_i,
  input  wire logic signed [COORD_BITS-1:0]  cell_z_i,
  input  wire logic [FRAC_BITS-1:0]          fraction_i,
  input  wire logic [VOLUME_BITS-1:0]        cell_volume_i,
  input  wire logic                          last_cell_i,
  input  wire logic [FIFO_CW-1:0]            fifo_count_i,
  output logic                               push_o,
  output rmvi_entry_t                        push_entry_o
);

  // Absolute difference of two signed coordinates
  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_BITS-1:0] a,
                                                 logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic accept;
  logic [FIFO_CW:0] in_use;

  // Stage 1: offsets
  logic                   s1_valid_q;
  logic [DIFF_W-1:0]      s1_ax_q, s1_ay_q, s1_az_q, s1_h0_q;
  logic                   s1_frac_ok_q;
  logic [FRAC_BITS-1:0]   s1_frac_q;
  logic [VOLUME_BITS-1:0] s1_vol_q;
  logic                   s1_last_q;

  // Stage 2: squares, cone terms, limit compares, product
  logic                   s2_valid_q;
  logic [SQ_W-1:0]        s2_sx_q, s2_sy_q, s2_sz_q, s2_rsq_q;
  logic [CMP_W-1:0]       s2_lhs_q, s2_rhs_q;
  logic                   s2_slope_pos_q;
  logic                   s2_in_x_q, s2_in_y_q, s2_in_z_q, s2_over_z_q;
  logic                   s2_frac_ok_q;
  logic [PROD_W-1:0]      s2_prod_q;
  logic                   s2_last_q;

  // Credit check: queue slots must cover everything still in the pipe
  assign in_use     = (FIFO_CW+1)'(fifo_count_i) + (FIFO_CW+1)'(s1_valid_q)
                    + (FIFO_CW+1)'(s2_valid_q);
  assign in_ready_o = in_use < (FIFO_CW+1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    s1_ax_q      <= abs_diff(cell_x_i, cfg_i.origin_x);
    s1_ay_q      <= abs_diff(cell_y_i, cfg_i.origin_y);
    s1_az_q      <= abs_diff(cell_z_i, cfg_i.origin_z);
    s1_h0_q      <= abs_diff(cell_z_i, cfg_i.apex_z);
    s1_frac_ok_q <= fraction_i > cfg_i.threshold;
    s1_frac_q    <= fraction_i;
    s1_vol_q     <= cell_volume_i;
    s1_last_q    <= last_cell_i;
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    s2_sx_q        <= SQ_W'(s1_ax_q) * SQ_W'(s1_ax_q);
    s2_sy_q        <= SQ_W'(s1_ay_q) * SQ_W'(s1_ay_q);
    s2_sz_q        <= SQ_W'(s1_az_q) * SQ_W'(s1_az_q);
    s2_rsq_q       <= SQ_W'(cfg_i.radius) * SQ_W'(cfg_i.radius);
    s2_lhs_q       <= CMP_W'({s1_ax_q, {SLOPE_FRAC{1'b0}}});
    s2_rhs_q       <= CMP_W'(RHS_W'(cfg_i.slope[SLOPE_BITS-2:0]) * RHS_W'(s1_h0_q));
    s2_slope_pos_q <= !cfg_i.slope[SLOPE_BITS-1];
    s2_in_x_q      <= s1_ax_q < DIFF_W'(cfg_i.half_x);
    s2_in_y_q      <= s1_ay_q < DIFF_W'(cfg_i.half_y);
    s2_in_z_q      <= s1_az_q < DIFF_W'(cfg_i.half_z);
    s2_over_z_q    <= s1_az_q > DIFF_W'(cfg_i.half_z);
    s2_frac_ok_q   <= s1_frac_ok_q;
    s2_prod_q      <= PROD_W'(s1_frac_q) * PROD_W'(s1_vol_q);
    s2_last_q      <= s1_last_q;
  end

  // Region decision and queue entry
  logic [SQ3_W-1:0] sum3, sum2;
  logic             in_region;

  always_comb begin
    sum2 = SQ3_W'(s2_sx_q) + SQ3_W'(s2_sy_q);
    sum3 = sum2 + SQ3_W'(s2_sz_q);
    case (cfg_i.mode)
      MODE_SPHERE:   in_region = sum3 < SQ3_W'(s2_rsq_q);
      MODE_CYLINDER: in_region = (sum2 < SQ3_W'(s2_rsq_q)) && s2_in_z_q;
      MODE_BOX:      in_region = s2_in_x_q && s2_in_y_q && s2_in_z_q;
      MODE_CONE:     in_region = !s2_over_z_q && s2_slope_pos_q && (s2_lhs_q < s2_rhs_q);
      default:       in_region = 1'b0;
    endcase
  end

  assign push_o              = s2_valid_q;
  assign push_entry_o.last   = s2_last_q;
  assign push_entry_o.addend = (in_region && s2_frac_ok_q) ? s2_prod_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/rmvi_fifo.sv -----
// Short queue of classified cells between the front end and the accumulator.
`default_nettype none

module rmvi_fifo
  import rmvi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire rmvi_entry_t  push_entry_i,
  input  wire logic         pop_i,
  output logic              pop_valid_o,
  output rmvi_entry_t       pop_entry_o,
  output logic [FIFO_CW-1:0] count_o
);

  rmvi_entry_t               slots_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]        count_q, count_d;
  logic                      do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) count_d = count_q + FIFO_CW'(1);
    else if (!push_i && do_pop) count_d = count_q - FIFO_CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_entry_i;
  end

  assign pop_valid_o = count_q != '0;
  assign pop_entry_o = slots_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rmvi_back.sv -----
// Back end: saturating accumulator and the result register.
`default_nettype none

module rmvi_back
  import rmvi_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_valid_i,
  input  wire rmvi_entry_t          pop_entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [SUM_BITS-1:0]       water_volume_o,
  output logic                      saturated_o
);

  logic [SUM_BITS-1:0] sum_q, out_sum_q, new_sum;
  logic                sat_q, out_sat_q, new_sat, out_valid_q;
  logic [ADD_W-1:0]    raw_sum;
  logic                ovf;

  // A last cell needs a free result slot; others go straight into the sum
  assign pop_o = pop_valid_i && (!pop_entry_i.last || !out_valid_q || out_ready_i);

  // Saturating add
  assign raw_sum = ADD_W'(sum_q) + ADD_W'(pop_entry_i.addend);
  assign ovf     = raw_sum[ADD_W-1:SUM_BITS] != '0;
  assign new_sum = ovf ? {SUM_BITS{1'b1}} : raw_sum[SUM_BITS-1:0];
  assign new_sat = sat_q || ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (pop_o) begin
        if (pop_entry_i.last) begin
          sum_q       <= '0;
          sat_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          sum_q <= new_sum;
          sat_q <= new_sat;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && pop_entry_i.last) begin
      out_sum_q <= new_sum;
      out_sat_q <= new_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign water_volume_o = out_sum_q;
  assign saturated_o    = out_sat_q;

endmodule

`default_nettype wire

// ----- hw/rtl/region_masked_volume_integral.sv -----
// Top level of the region-masked volume integral block.
// Takes one mesh cell per transaction and sums fraction * volume over cells whose
// center lies in the configured region (sphere, z cylinder, box or cone) and whose
// fraction is above the threshold; the cell marked last returns the sum and a
// saturation flag and clears the sum. A new cell can be taken every cycle while
// input ready is high. A cell passes through the front end (offsets, then squares
// and products), enters an eight-entry queue, and then reaches the accumulator,
// which registers the result. Input ready drops when the queue plus cells still in
// the front end already fill the queue.
`default_nettype none

module region_masked_volume_integral
  import rmvi_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_BITS-1:0]  cell_x_i,
  input  wire logic signed [COORD_BITS-1:0]  cell_y_i,
  input  wire logic signed [COORD_BITS-1:0]  cell_z_i,
  input  wire logic [FRAC_BITS-1:0]          fraction_i,
  input  wire logic [VOLUME_BITS-1:0]        cell_volume_i,
  input  wire logic                          last_cell_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [SUM_BITS-1:0]                water_volume_o,
  output logic                               saturated_o
);

  rmvi_cfg_t          cfg;
  logic               push, pop, pop_valid;
  rmvi_entry_t        push_entry, pop_entry;
  logic [FIFO_CW-1:0] fifo_count;

  rmvi_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rmvi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .fraction_i    (fraction_i),
    .cell_volume_i (cell_volume_i),
    .last_cell_i   (last_cell_i),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  rmvi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .count_o      (fifo_count)
  );

  rmvi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_entry_i    (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .water_volume_o (water_volume_o),
    .saturated_o    (saturated_o)
  );

endmodule

`default_nettype wire
